/* hdl/sed_pkg.sv */
package sed_pkg;

    localparam logic [7:0]  STX_BYTE      = 8'h02;
    localparam logic [7:0]  ETX_BYTE      = 8'h03;
    localparam int          POS_W         = 17;
    localparam logic [POS_W-1:0] POS_MAX  = '1;
    localparam logic [POS_W-1:0] HDR_SIZE      = POS_W'(16);
    localparam logic [POS_W-1:0] PAYLOAD_START = POS_W'(15);
    localparam logic [POS_W-1:0] CRC_FIRST     = POS_W'(1);
    localparam logic [POS_W-1:0] CRC_LAST      = POS_W'(8);
    localparam logic [POS_W-1:0] LEN_FIRST     = POS_W'(10);
    localparam logic [POS_W-1:0] LEN_LAST      = POS_W'(13);
    localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd9984;

    typedef enum logic [2:0] {
        ST_GOOD      = 3'd0,
        ST_CRC_BAD   = 3'd1,
        ST_SHORT_HDR = 3'd2,
        ST_BAD_HEX   = 3'd3,
        ST_SHORT_PAY = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        t_status    frame_status;
    } t_result;

    // Returns {bad, nibble}; a non-hex byte decodes as zero with bad set.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = {1'b1, 4'h0};
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b0, 4'(b - 8'h37)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b0, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    // One byte of MSB-first CRC-32, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/sed_if.sv */
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sed_out_if;
    logic                 valid;
    logic                 ready;
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic                 frame_done;
    logic [2:0]           frame_status;
    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_done, input frame_status, output ready);
endinterface

interface sed_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_payload_length;
    modport source (output valid, output max_payload_length, input ready);
    modport sink   (input valid, input max_payload_length, output ready);
endinterface

/* hdl/sed_in_stage.sv */
module sed_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output logic       o_vld,
    output logic [7:0] o_byte
);
    logic       r_vld;
    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;
endmodule

/* hdl/sed_frame.sv */
module sed_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [7:0]           i_byte,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    output sed_pkg::t_result     o_res
);
    logic                       r_in_frame, n_in_frame;
    logic [sed_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [31:0]                r_hdr_crc, n_hdr_crc;
    logic [15:0]                r_hdr_len, n_hdr_len;
    logic [31:0]                r_crc, n_crc;
    logic                       r_hdr_bad, n_hdr_bad;
    logic [15:0]                r_max_len;
    logic [4:0]                 hex;
    logic [sed_pkg::POS_W-1:0]  pay_idx;
    logic                       len_ok;
    sed_pkg::t_result           res;

    assign hex     = sed_pkg::hex_decode(i_byte);
    assign pay_idx = r_pos - sed_pkg::PAYLOAD_START;
    assign len_ok  = (r_hdr_len <= r_max_len);

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_hdr_crc  = r_hdr_crc;
        n_hdr_len  = r_hdr_len;
        n_crc      = r_crc;
        n_hdr_bad  = r_hdr_bad;
        res        = '0;
        if (i_go) begin
            if (i_byte == sed_pkg::STX_BYTE) begin
                n_in_frame = 1'b1;
                n_pos      = sed_pkg::CRC_FIRST;
                n_hdr_crc  = '0;
                n_hdr_len  = '0;
                n_crc      = sed_pkg::CRC_INIT;
                n_hdr_bad  = 1'b0;
            end else if (r_in_frame) begin
                if (i_byte == sed_pkg::ETX_BYTE) begin
                    res.frame_done = 1'b1;
                    n_in_frame     = 1'b0;
                    if (r_pos < sed_pkg::HDR_SIZE) begin
                        res.frame_status = sed_pkg::ST_SHORT_HDR;
                    end else if (r_hdr_bad) begin
                        res.frame_status = sed_pkg::ST_BAD_HEX;
                    end else if (!len_ok) begin
                        res.frame_status = sed_pkg::ST_TOO_LONG;
                    end else if (pay_idx < {1'b0, r_hdr_len}) begin
                        res.frame_status = sed_pkg::ST_SHORT_PAY;
                    end else if (~r_crc != r_hdr_crc) begin
                        res.frame_status = sed_pkg::ST_CRC_BAD;
                    end else begin
                        res.frame_status = sed_pkg::ST_GOOD;
                    end
                end else begin
                    if (r_pos inside {[sed_pkg::CRC_FIRST:sed_pkg::CRC_LAST]}) begin
                        n_hdr_crc = {r_hdr_crc[27:0], hex[3:0]};
                        n_hdr_bad = r_hdr_bad | hex[4];
                    end else if (r_pos inside {[sed_pkg::LEN_FIRST:sed_pkg::LEN_LAST]}) begin
                        n_hdr_len = {r_hdr_len[11:0], hex[3:0]};
                        n_hdr_bad = r_hdr_bad | hex[4];
                    end else if (r_pos >= sed_pkg::PAYLOAD_START) begin
                        if ((pay_idx < {1'b0, r_hdr_len}) && !r_hdr_bad && len_ok) begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = i_byte;
                            n_crc             = sed_pkg::crc_byte(r_crc, i_byte);
                        end
                    end
                    if (r_pos != sed_pkg::POS_MAX) begin
                        n_pos = r_pos + sed_pkg::POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_hdr_crc  <= '0;
            r_hdr_len  <= '0;
            r_crc      <= sed_pkg::CRC_INIT;
            r_hdr_bad  <= 1'b0;
            r_max_len  <= sed_pkg::MAX_LEN_RESET;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_hdr_crc  <= n_hdr_crc;
            r_hdr_len  <= n_hdr_len;
            r_crc      <= n_crc;
            r_hdr_bad  <= n_hdr_bad;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    assign o_res = res;

`ifndef NO_ASSERTIONS
    a_done_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.frame_done |-> !res.payload_valid)
        else $error("frame end and payload byte in one result");
    a_stx_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_byte == sed_pkg::STX_BYTE) |=> (r_in_frame && r_pos == sed_pkg::CRC_FIRST))
        else $error("start byte did not open a frame");
    a_etx_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.frame_done |=> !r_in_frame)
        else $error("frame still open after its end byte");
    a_payload_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.payload_valid |-> (r_in_frame && r_pos >= sed_pkg::PAYLOAD_START && !r_hdr_bad))
        else $error("payload byte passed outside the payload area");
`endif
endmodule

/* hdl/sed_out_stage.sv */
module sed_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_taken,
    input  sed_pkg::t_result i_res,
    output logic             o_vld,
    output sed_pkg::t_result o_res
);
    logic             r_vld;
    sed_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_taken) begin
            r_vld <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;
endmodule

/* hdl/stx_etx_hex_crc_deframer.sv */
// Receiver for STX/ETX framed byte streams with a hex text header and a CRC-32 check.
// Input channel i_in carries one link byte per beat in rx_byte. Output channel o_out
// returns exactly one result beat per input beat: a passed payload byte
// (payload_valid, payload_byte), or a frame report (frame_done, frame_status) when
// the beat was the ETX closing a frame, or an all-zero beat otherwise.
// Configuration channel i_cfg writes max_payload_length; it is always ready and
// should only be written while no beat is in flight.
// An accepted input beat goes through the input register and then the output register.
// Throughput is one beat per cycle unless o_out stalls: the byte is held in an input
// register, the header digit decode and the one-byte CRC-32 update are done in a
// single pass of logic, and the result lands in an output register.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more beat; after that i_in.ready drops until the
// output beat is taken.
// Reset (synchronous, active low) empties both registers, leaves the block outside
// any frame and restores max_payload_length to 9984.
module stx_etx_hex_crc_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sed_in_if.sink    i_in,
    sed_out_if.source o_out,
    sed_cfg_if.sink   i_cfg
);
    logic             in_vld;
    logic [7:0]       in_byte;
    logic             out_vld;
    logic             advance;
    logic             in_load;
    sed_pkg::t_result frame_res;
    sed_pkg::t_result out_res;

    // The held byte moves on whenever the output register is free or being emptied.
    assign advance    = in_vld && (!out_vld || o_out.ready);
    assign i_in.ready = !in_vld || advance;
    assign in_load    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    sed_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_load),
        .i_advance (advance),
        .i_byte    (i_in.rx_byte),
        .o_vld     (in_vld),
        .o_byte    (in_byte)
    );

    sed_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (advance),
        .i_byte     (in_byte),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.max_payload_length),
        .o_res      (frame_res)
    );

    sed_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_taken (o_out.ready),
        .i_res   (frame_res),
        .o_vld   (out_vld),
        .o_res   (out_res)
    );

    assign o_out.valid         = out_vld;
    assign o_out.payload_valid = out_res.payload_valid;
    assign o_out.payload_byte  = out_res.payload_byte;
    assign o_out.frame_done    = out_res.frame_done;
    assign o_out.frame_status  = out_res.frame_status;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_vld && out_vld && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both registers are full and stalled");
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> out_vld)
        else $error("processed beat did not reach the output register");
    a_load_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load |=> in_vld)
        else $error("accepted beat missing from the input register");
`endif
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the STX/ETX hex-header deframer.
// A byte stream is queued by the stimulus process and offered one beat at a time by the
// link-side driver. Every accepted beat is run through a behavioral deframer in this file,
// and the result it produces is queued. The result-side process pulls beats from the
// block and checks each one, field by field, against the oldest queued result.
module tb_top;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    sed_in_if  in_if ();
    sed_out_if out_if ();
    sed_cfg_if cfg_if ();

    stx_etx_hex_crc_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // Bytes still to be offered on the link side, and results owed by the block.
    t_byte_q          link_bytes;
    sed_pkg::t_result results_owed[$];

    int  bytes_queued = 0;
    int  mismatches   = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    bit  hold_go      = 1'b0;
    logic hold_rx;

    // Behavioral copy of the deframer state. The limit follows every register write.
    logic        fr_open;
    logic [16:0] fr_pos;
    logic [31:0] fr_crc_hdr;
    logic [15:0] fr_len;
    logic [31:0] fr_crc_run;
    logic        fr_bad;
    logic [15:0] len_limit;

    // Decodes one hex character. Bit 4 is set for anything that is not a hex digit,
    // and such a byte counts as a zero nibble.
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
        return 5'h10;
    endfunction

    // One byte of the MSB-first CRC-32, shifted bit by bit.
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h0};
        repeat (8) r = r[31] ? ({r[30:0], 1'b0} ^ sed_pkg::CRC_POLY) : {r[30:0], 1'b0};
        return r;
    endfunction

    // Advances the deframer by one link byte and returns the result beat it owes.
    function automatic sed_pkg::t_result deframe_byte(input logic [7:0] b);
        sed_pkg::t_result r;
        logic [4:0]       d;
        int               idx;
        r = '0;
        d = nibble_of(b);
        if (b == sed_pkg::STX_BYTE) begin
            // A start byte always opens a fresh frame; a partial one is dropped silently.
            fr_open    = 1'b1;
            fr_pos     = 17'd1;
            fr_crc_hdr = '0;
            fr_len     = '0;
            fr_crc_run = '1;
            fr_bad     = 1'b0;
        end else if (fr_open) begin
            idx = int'(fr_pos) - 15;
            if (b == sed_pkg::ETX_BYTE) begin
                // The end byte closes the frame wherever it falls. The status checks run
                // in a fixed order of priority.
                r.frame_done = 1'b1;
                if (fr_pos < 17'd16)                 r.frame_status = sed_pkg::ST_SHORT_HDR;
                else if (fr_bad)                     r.frame_status = sed_pkg::ST_BAD_HEX;
                else if (fr_len > len_limit)         r.frame_status = sed_pkg::ST_TOO_LONG;
                else if (idx < int'(fr_len))         r.frame_status = sed_pkg::ST_SHORT_PAY;
                else if (~fr_crc_run != fr_crc_hdr)  r.frame_status = sed_pkg::ST_CRC_BAD;
                else                                 r.frame_status = sed_pkg::ST_GOOD;
                fr_open = 1'b0;
            end else begin
                if (fr_pos >= 17'd1 && fr_pos <= 17'd8) begin
                    fr_crc_hdr = {fr_crc_hdr[27:0], d[3:0]};
                    fr_bad     = fr_bad | d[4];
                end else if (fr_pos >= 17'd10 && fr_pos <= 17'd13) begin
                    fr_len = {fr_len[11:0], d[3:0]};
                    fr_bad = fr_bad | d[4];
                end else if (fr_pos >= 17'd15) begin
                    // Only the first fr_len payload bytes of a sound header pass out.
                    if (idx < int'(fr_len) && !fr_bad && fr_len <= len_limit) begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        fr_crc_run      = crc_step(fr_crc_run, b);
                    end
                end
                // The position counter sticks at its top value in very long frames.
                if (fr_pos != '1) fr_pos = fr_pos + 17'd1;
            end
        end
        return r;
    endfunction

    // Gap after a beat: usually none, often a short one, now and then a long one.
    function automatic int pick_gap(input bit en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        if ($urandom_range(0, 1)) return 8'h61 + 8'(n) - 8'd10;
        return 8'h41 + 8'(n) - 8'd10;
    endfunction

    // Any byte that neither opens nor closes a frame.
    function automatic logic [7:0] link_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == sed_pkg::STX_BYTE || b == sed_pkg::ETX_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] d;
        do begin
            b = link_byte();
            d = nibble_of(b);
        end while (!d[4]);
        return b;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Builds a frame around a payload. The header CRC covers the bytes that the length
    // field lets through and can be spoiled in one bit; one of the twelve digit
    // positions can be replaced by a non-hex byte; the frame can be cut short after
    // byte number cut, and the closing end byte can be left off.
    task automatic push_frame(input t_byte_q pay, input logic [15:0] len_field,
                              input bit crc_flip, input int bad_digit, input int cut,
                              input bit close);
        t_byte_q     f;
        logic [31:0] crc;
        int          n;
        crc = '1;
        n   = (pay.size() < int'(len_field)) ? pay.size() : int'(len_field);
        for (int i = 0; i < n; i++) crc = crc_step(crc, pay[i]);
        crc = ~crc;
        if (crc_flip) crc = crc ^ (32'h1 << $urandom_range(0, 31));
        f.push_back(sed_pkg::STX_BYTE);
        for (int i = 7; i >= 0; i--) f.push_back(hex_char(crc[i*4 +: 4]));
        f.push_back(link_byte());
        for (int i = 3; i >= 0; i--) f.push_back(hex_char(len_field[i*4 +: 4]));
        f.push_back(link_byte());
        f = {f, pay};
        if (bad_digit >= 0) f[bad_digit < 8 ? bad_digit + 1 : bad_digit + 2] = non_hex_byte();
        if (cut >= 0 && cut < f.size()) f = f[0:cut];
        foreach (f[i]) queue_byte(f[i]);
        if (close) queue_byte(sed_pkg::ETX_BYTE);
    endtask

    // Mostly well-formed frames with random content; the rest spoil the CRC, a digit,
    // the payload count or the length limit, break off early or hold a stray STX or ETX byte.
    task automatic push_random_frame();
        t_byte_q pay;
        int      kind, len, n_pay, cap, bad, cut;
        bit      flip, close;
        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
        end
        kind  = $urandom_range(0, 99);
        cap   = (int'(len_limit) < 12) ? int'(len_limit) : 12;
        len   = $urandom_range(0, cap);
        if ($urandom_range(0, 9) == 0) len = (int'(len_limit) < 80) ? int'(len_limit) : 80;
        n_pay = len + $urandom_range(0, 3);
        flip  = 1'b0;
        bad   = -1;
        cut   = -1;
        close = 1'b1;
        if (kind < 55) begin
            // well-formed
        end else if (kind < 65) begin
            flip = 1'b1;
        end else if (kind < 72) begin
            bad = $urandom_range(0, 11);
        end else if (kind < 80) begin
            n_pay = (len > 0) ? $urandom_range(0, len - 1) : 0;
        end else if (kind < 86) begin
            if (len_limit != 16'hFFFF) begin
                len = int'(len_limit) + $urandom_range(1, 8);
                if (len > 65535) len = 65535;
            end else begin
                len = $urandom_range(1000, 65535);
            end
            n_pay = $urandom_range(0, 4);
        end else if (kind < 91) begin
            cut = $urandom_range(0, 13);
        end else if (kind < 95) begin
            cut   = $urandom_range(0, 14 + n_pay);
            close = 1'b0;
        end
        for (int i = 0; i < n_pay; i++) pay.push_back(link_byte());
        // A stray start or end byte inside the payload.
        if (kind >= 95 && n_pay > 0) pay[$urandom_range(0, n_pay - 1)] = 8'($urandom_range(2, 3));
        push_frame(pay, 16'(len), flip, bad, cut, close);
    endtask

    task automatic run_random(input int n_bytes);
        int target;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) push_random_frame();
    endtask

    // Returns once every queued byte has gone in and every owed result has come out.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (link_bytes.size() != 0 || in_if.valid || results_owed.size() != 0);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(posedge i_clk);
        cfg_if.valid              <= 1'b1;
        cfg_if.max_payload_length <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        len_limit    = v;
        cfg_if.valid <= 1'b0;
    endtask

    // Link-side driver. A beat leaves when the block takes it; the next one is offered
    // from the queue after a random gap.
    always @(posedge i_clk) begin : link_driver
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_wait     <= 0;
        end else begin
            if (in_if.valid && in_if.ready) results_owed.push_back(deframe_byte(in_if.rx_byte));
            if (!in_if.valid || in_if.ready) begin
                if (tx_wait > 0) begin
                    in_if.valid <= 1'b0;
                    tx_wait     <= tx_wait - 1;
                end else if (link_bytes.size() > 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.rx_byte <= link_bytes.pop_front();
                    tx_wait       <= pick_gap(tx_idle_en);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result-side monitor. Each beat taken is checked against the oldest owed result,
    // and ready drops for a random gap after it or while the long hold-off runs.
    always @(posedge i_clk) begin : result_monitor
        sed_pkg::t_result want;
        int               gap;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait      <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (results_owed.size() == 0) begin
                    $display("%0t: unexpected beat expected none got %b %h %b %0d", $time,
                             out_if.payload_valid, out_if.payload_byte, out_if.frame_done,
                             out_if.frame_status);
                    mismatches++;
                end else begin
                    want = results_owed.pop_front();
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(out_if.payload_valid));
                    check_field("payload_byte", want.payload_byte, out_if.payload_byte);
                    check_field("frame_done", 8'(want.frame_done), 8'(out_if.frame_done));
                    check_field("frame_status", 8'(want.frame_status),
                                8'(out_if.frame_status));
                end
                gap = pick_gap(rx_idle_en);
            end else begin
                gap = (rx_wait > 0) ? rx_wait - 1 : 0;
            end
            rx_wait      <= gap;
            out_if.ready <= !hold_rx && gap == 0;
        end
    end

    // Long hold-off on the result side. The link side keeps offering beats meanwhile,
    // so both registers of the block fill up and it has to stall its input.
    initial begin : result_hold
        hold_rx = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_byte_q pay;
        i_rst_n                   = 1'b0;
        in_if.valid               = 1'b0;
        in_if.rx_byte             = 8'h00;
        out_if.ready              = 1'b0;
        cfg_if.valid              = 1'b0;
        cfg_if.max_payload_length = 16'h0000;
        fr_open                   = 1'b0;
        fr_pos                    = '0;
        fr_crc_hdr                = '0;
        fr_len                    = '0;
        fr_crc_run                = '1;
        fr_bad                    = 1'b0;
        len_limit                 = sed_pkg::MAX_LEN_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset limit: bytes outside a frame, an end byte with
        // no frame open, a frame closed right after its start byte, then a good frame
        // whose payload holds both extreme byte values and one byte past its length.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(sed_pkg::ETX_BYTE);
        queue_byte(sed_pkg::STX_BYTE);
        queue_byte(sed_pkg::ETX_BYTE);
        pay = '{8'h00, 8'hFF, 8'h5A};
        push_frame(pay, 16'd2, 1'b0, -1, -1, 1'b1);
        wait_idle();

        // Random frames at the reset limit, with gaps on both sides.
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random(300);
        wait_idle();

        // A zero limit: only empty payloads are accepted.
        write_limit(16'h0000);
        run_random(200);
        wait_idle();

        // The widest limit, with the result side held off for a long stretch.
        write_limit(16'hFFFF);
        hold_go = 1'b1;
        run_random(300);
        wait_idle();

        // A small random limit, so that lengths at and just over it come up often.
        write_limit(16'($urandom_range(16, 64)));
        run_random(350);
        wait_idle();

        // A final wait shows up any stray beat.
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
